// File: hw/rtl/gsr_pkg.sv
// shared types and constants of the gradient stop rectifier
package gsr_pkg;

	localparam int POS_W       = 16;
	localparam int MID_W       = 7;
	localparam int CHAN_W      = 16;
	localparam int OCHAN_W     = CHAN_W + 1;
	localparam int STOP_W      = 32;
	localparam int ZPOS_W      = 23;
	localparam int POS_SCALE   = 100;
	localparam int NO_EXTRA_MID = 50;
	localparam int QUEUE_DEPTH = 2;

	// register indexes
	localparam int REG_CHANNEL_MODE = 0;

	// stop candidates of one segment, in emission order
	typedef enum logic [2:0] {
		CAND_LEAD,
		CAND_PREV,
		CAND_MID,
		CAND_CUR,
		CAND_END,
		CAND_TOO_FEW
	} cand_t;

	localparam int NCAND = 6;

	// one classified segment waiting for the back end
	typedef struct packed {
		logic [NCAND-1:0]  mask;
		logic              mode;
		logic              last;
		logic [ZPOS_W-1:0] zprev;
		logic [ZPOS_W-1:0] zcur;
		logic [STOP_W-1:0] prod;
		logic [CHAN_W-1:0] prev_a;
		logic [CHAN_W-1:0] prev_b;
		logic [CHAN_W-1:0] prev_c;
		logic [CHAN_W-1:0] cur_a;
		logic [CHAN_W-1:0] cur_b;
		logic [CHAN_W-1:0] cur_c;
	} job_t;

	// one emitted stop
	typedef struct packed {
		logic [STOP_W-1:0]  position;
		logic [OCHAN_W-1:0] a;
		logic [OCHAN_W-1:0] b;
		logic [OCHAN_W-1:0] c;
		logic               run_last;
		logic               list_end;
		logic               too_few;
	} stop_t;

endpackage

// File: hw/rtl/gsr_front.sv
// front end: accepts segments, keeps the previous one and classifies stop candidates
module gsr_front #(
	parameter int unsigned END_POSITION = 409600
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        mode,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [gsr_pkg::POS_W-1:0]   position,
	input  logic [gsr_pkg::MID_W-1:0]   midpoint,
	input  logic [gsr_pkg::CHAN_W-1:0]  chan_a,
	input  logic [gsr_pkg::CHAN_W-1:0]  chan_b,
	input  logic [gsr_pkg::CHAN_W-1:0]  chan_c,
	input  logic                        last_segment,
	output logic                        push_valid,
	input  logic                        push_ready,
	output gsr_pkg::job_t               push_job
);
	import gsr_pkg::*;

	logic [POS_W-1:0]  prev_position_q;
	logic [MID_W-1:0]  prev_midpoint_q;
	logic [CHAN_W-1:0] prev_a_q;
	logic [CHAN_W-1:0] prev_b_q;
	logic [CHAN_W-1:0] prev_c_q;
	logic              have_prev_q;

	logic signed [POS_W:0]   diff;
	logic signed [POS_W+MID_W+1:0] prod_n;
	logic [ZPOS_W-1:0]       zcur;
	logic                    accept;

	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign accept     = in_valid && push_ready;

	always_comb begin
		diff   = $signed({1'b0, position}) - $signed({1'b0, prev_position_q});
		prod_n = diff * $signed({1'b0, prev_midpoint_q});
		zcur   = ZPOS_W'(position) * ZPOS_W'(POS_SCALE);

		push_job        = '0;
		push_job.mode   = mode;
		push_job.last   = last_segment;
		push_job.zprev  = ZPOS_W'(prev_position_q) * ZPOS_W'(POS_SCALE);
		push_job.zcur   = zcur;
		push_job.prod   = {{(STOP_W-POS_W-MID_W-2){prod_n[POS_W+MID_W+1]}}, prod_n};
		push_job.prev_a = prev_a_q;
		push_job.prev_b = prev_b_q;
		push_job.prev_c = prev_c_q;
		push_job.cur_a  = chan_a;
		push_job.cur_b  = chan_b;
		push_job.cur_c  = chan_c;

		push_job.mask[CAND_TOO_FEW] = !have_prev_q && last_segment;
		push_job.mask[CAND_LEAD]    = !have_prev_q && !last_segment && mode
			&& (position != '0);
		push_job.mask[CAND_PREV]    = have_prev_q;
		push_job.mask[CAND_MID]     = have_prev_q
			&& (prev_midpoint_q != MID_W'(NO_EXTRA_MID));
		push_job.mask[CAND_CUR]     = have_prev_q && last_segment;
		push_job.mask[CAND_END]     = have_prev_q && last_segment
			&& ({{(STOP_W-ZPOS_W){1'b0}}, zcur} < STOP_W'(END_POSITION));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
		end else if (accept) begin
			have_prev_q <= !last_segment;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prev_position_q <= position;
			prev_midpoint_q <= midpoint;
			prev_a_q        <= chan_a;
			prev_b_q        <= chan_b;
			prev_c_q        <= chan_c;
		end
	end

endmodule

// File: hw/rtl/gsr_queue.sv
// short job queue between front and back end
module gsr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  gsr_pkg::job_t  push_job,
	output logic           pop_valid,
	input  logic           pop,
	output gsr_pkg::job_t  pop_job
);
	import gsr_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_job    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// File: hw/rtl/gsr_back.sv
// back end: expands jobs into stops one per cycle while the stop output is not held, trims past the end position
module gsr_back #(
	parameter int unsigned END_POSITION = 409600
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	input  gsr_pkg::job_t  job,
	output logic           job_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output gsr_pkg::stop_t out_stop
);
	import gsr_pkg::*;

	logic [NCAND-1:0] done_q;
	logic             trimmed_q;
	logic             out_valid_q;
	stop_t            stop_q;

	logic [NCAND-1:0] rem;
	logic [NCAND-1:0] sel_hot;
	cand_t            sel;
	logic             more;
	logic             is_tf;
	logic             drop;
	logic             emit;
	logic             advance;
	logic             fire;
	logic             ge;
	logic             is_last;
	stop_t            stop_d;

	always_comb begin
		rem = job.mask & ~done_q;
		sel = CAND_LEAD;
		for (int i = NCAND - 1; i >= 0; i--) begin
			if (rem[i]) begin
				sel = cand_t'(i);
			end
		end
		sel_hot = NCAND'(1) << sel;
		more    = |(rem & ~sel_hot);
		is_tf   = sel == CAND_TOO_FEW;

		stop_d = '0;
		unique case (sel)
			CAND_LEAD: begin
				stop_d.position = '0;
				stop_d.a = {job.cur_a, 1'b0};
				stop_d.b = {job.cur_b, 1'b0};
				stop_d.c = {job.cur_c, 1'b0};
			end
			CAND_PREV: begin
				stop_d.position = STOP_W'(job.zprev);
				stop_d.a = {job.prev_a, 1'b0};
				stop_d.b = {job.prev_b, 1'b0};
				stop_d.c = {job.prev_c, 1'b0};
			end
			CAND_MID: begin
				stop_d.position = STOP_W'(job.zprev) + job.prod;
				stop_d.a = OCHAN_W'(job.prev_a) + OCHAN_W'(job.cur_a);
				stop_d.b = OCHAN_W'(job.prev_b) + OCHAN_W'(job.cur_b);
				stop_d.c = OCHAN_W'(job.prev_c) + OCHAN_W'(job.cur_c);
			end
			CAND_CUR: begin
				stop_d.position = STOP_W'(job.zcur);
				stop_d.a = {job.cur_a, 1'b0};
				stop_d.b = {job.cur_b, 1'b0};
				stop_d.c = {job.cur_c, 1'b0};
			end
			CAND_END: begin
				stop_d.position = STOP_W'(END_POSITION);
				stop_d.a = {job.cur_a, 1'b0};
				stop_d.b = {job.cur_b, 1'b0};
				stop_d.c = {job.cur_c, 1'b0};
			end
			CAND_TOO_FEW: begin
				stop_d.position = '0;
			end
			default: begin
				stop_d.position = '0;
			end
		endcase

		// opacity mode carries one channel only
		if (job.mode) begin
			stop_d.b = '0;
			stop_d.c = '0;
		end

		ge      = !is_tf && (stop_d.position >= STOP_W'(END_POSITION));
		is_last = is_tf || !more || ge;
		stop_d.run_last = is_last;
		stop_d.too_few  = is_tf;
		stop_d.list_end = !is_tf && (ge || (job.last && is_last));

		advance = !out_valid_q || out_ready;
		drop    = job_valid && (rem != '0) && trimmed_q && !is_tf;
		emit    = job_valid && (rem != '0) && !(trimmed_q && !is_tf);
		fire    = emit && advance;
		job_pop = job_valid && ((rem == '0) || drop || (fire && is_last));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= '0;
			trimmed_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= emit;
			end
			if (job_pop) begin
				done_q <= '0;
			end else if (fire) begin
				done_q <= done_q | sel_hot;
			end
			if (job_pop && job.last) begin
				trimmed_q <= 1'b0;
			end else if (fire && ge) begin
				trimmed_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			stop_q <= stop_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_stop  = stop_q;

	a_too_few_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && stop_q.too_few |-> stop_q.run_last && !stop_q.list_end)
		else $error("too_few stop must close the run and not end the list");

	a_end_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && stop_q.list_end |-> stop_q.run_last)
		else $error("list end without run end");

	a_trim_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		fire && ge && !job.last |=> trimmed_q)
		else $error("trimming not armed after end position reached");

	a_done_in_mask: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |-> (done_q & ~job.mask) == '0)
		else $error("handled candidates outside the job mask");

endmodule

// File: hw/rtl/gradient_stop_rectifier_unit.sv
// top level of the gradient stop rectifier: stream ports, register port, front, queue, back
// a segment is written into the queue, and its stops then pass through the back end's output register to m_axis
// throughput: one stop per cycle while m_axis is not stalled; the back end holds one segment until
//   all its stops are emitted or trimmed, and also frees a segment with none; single output register
// reset: arst_n clears the held segment, trimming state, queue, output register and mode;
//   no clearing pass, items are taken right after reset
module gradient_stop_rectifier_unit #(
	parameter int unsigned END_POSITION = 409600
) (
	input  logic        clk,
	input  logic        arst_n,
	// segment stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// position[15:0], midpoint[22:16], chan_a[38:23], chan_b[54:39], chan_c[70:55], pad
	input  logic [71:0] s_axis_tdata,
	// last_segment
	input  logic        s_axis_tlast,
	// stop stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// stop_position[31:0], out_a[48:32], out_b[65:49], out_c[82:66], pad
	output logic [87:0] m_axis_tdata,
	// run_last
	output logic        m_axis_tlast,
	// list_end[0], too_few[1]
	output logic [1:0]  m_axis_tuser,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import gsr_pkg::*;

	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 88;
	localparam int OUT_PAD_W  = OUT_DATA_W - STOP_W - 3 * OCHAN_W;

	// register map: channel_mode at byte address 0

	logic  channel_mode_q;
	logic  reg_write;
	logic  push_valid;
	logic  push_ready;
	job_t  push_job;
	logic  pop_valid;
	logic  pop;
	job_t  pop_job;
	stop_t stop;

	// register port: write completes in the access phase, no wait states
	assign pready    = 1'b1;
	assign reg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_mode_q <= 1'b0;
		end else if (reg_write && (paddr[2] == 1'(REG_CHANNEL_MODE))) begin
			channel_mode_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[2] == 1'(REG_CHANNEL_MODE)) ? {31'b0, channel_mode_q} : '0;

	// front: takes a segment transaction whenever the queue has room
	gsr_front #(
		.END_POSITION(END_POSITION)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.mode        (channel_mode_q),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.position    (s_axis_tdata[15:0]),
		.midpoint    (s_axis_tdata[22:16]),
		.chan_a      (s_axis_tdata[38:23]),
		.chan_b      (s_axis_tdata[54:39]),
		.chan_c      (s_axis_tdata[70:55]),
		.last_segment(s_axis_tlast),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_job    (push_job)
	);

	// decouples segment acceptance from stop emission
	gsr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_job  (push_job),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_job   (pop_job)
	);

	// back: walks the candidate stops of the head job, applies trimming
	gsr_back #(
		.END_POSITION(END_POSITION)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(pop_valid),
		.job      (pop_job),
		.job_pop  (pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_stop (stop)
	);

	// pack the stop transaction
	assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, stop.c, stop.b, stop.a, stop.position};
	assign m_axis_tlast = stop.run_last;
	assign m_axis_tuser = {stop.too_few, stop.list_end};

	// pad bit of the segment stream carries nothing
	logic unused_pad;
	assign unused_pad = s_axis_tdata[IN_DATA_W-1] ^ ^pwdata[31:1] ^ ^paddr[1:0];

endmodule

// File: dv/gradient_stop_rectifier_unit_tb.sv
// self-checking testbench of the gradient stop rectifier unit
`timescale 1ns / 1ps

module gradient_stop_rectifier_unit_tb;
	import gsr_pkg::*;

	localparam int unsigned END_POSITION = 409600;
	// byte addresses of the registers
	localparam logic [2:0] ADDR_CHANNEL_MODE = 3'(4 * REG_CHANNEL_MODE);
	localparam int MAX_STOPS = 4;
	// quiet cycles after the last stop, covers a segment still in the back end
	localparam int SETTLE_CYCLES = 10;
	localparam int LONG_HOLD_CYCLES = 120;
	localparam int CYCLE_LIMIT = 200000;
	localparam int ITEMS_PER_PHASE = 42;

	typedef enum bit {
		MODE_COLOR   = 1'b0,
		MODE_OPACITY = 1'b1
	} chan_mode_t;

	typedef struct packed {
		logic [POS_W-1:0]  position;
		logic [MID_W-1:0]  midpoint;
		logic [CHAN_W-1:0] chan_a;
		logic [CHAN_W-1:0] chan_b;
		logic [CHAN_W-1:0] chan_c;
		logic              last;
	} segment_t;

	// predicts the stops of each accepted segment and checks them in order
	class stop_tracker_t;
		chan_mode_t        mode;
		logic [POS_W-1:0]  held_pos;
		logic [MID_W-1:0]  held_mid;
		logic [CHAN_W-1:0] held_a, held_b, held_c;
		bit                have_held;
		bit                trimmed;
		stop_t             batch[MAX_STOPS];
		int                produced;
		stop_t             expected_stops[$];
		int mismatches, segments, gradients, stops_checked, mid_stops, lead_stops;
		int trimmed_lists, short_gradients;

		function new();
			mode = MODE_COLOR;
			held_pos = '0;
			held_mid = '0;
			held_a = '0;
			held_b = '0;
			held_c = '0;
			have_held = 0;
			trimmed = 0;
		endfunction

		function int pending();
			return expected_stops.size();
		endfunction

		// one stop, unless the list is already trimmed or the batch is full
		function void add_stop(logic [STOP_W-1:0] position, logic [OCHAN_W-1:0] a,
				logic [OCHAN_W-1:0] b, logic [OCHAN_W-1:0] c);
			stop_t s;
			if (trimmed || produced >= MAX_STOPS)
				return;
			s = '0;
			s.position = position;
			s.a = a;
			s.b = (mode == MODE_OPACITY) ? '0 : b;
			s.c = (mode == MODE_OPACITY) ? '0 : c;
			if (position >= END_POSITION) begin
				s.list_end = 1'b1;
				trimmed = 1;
				trimmed_lists++;
			end
			batch[produced] = s;
			produced++;
		endfunction

		function void take_segment(segment_t seg);
			logic [STOP_W-1:0] zprev, zcur, diff, zmid;
			produced = 0;
			segments++;
			if (seg.last)
				gradients++;
			if (!have_held && seg.last) begin
				// a gradient of one segment only yields the error stop
				batch[0] = '0;
				batch[0].run_last = 1'b1;
				batch[0].too_few = 1'b1;
				expected_stops.push_back(batch[0]);
				trimmed = 0;
				short_gradients++;
				return;
			end
			if (!have_held) begin
				if (mode == MODE_OPACITY && seg.position != '0) begin
					add_stop('0, {seg.chan_a, 1'b0}, {seg.chan_b, 1'b0}, {seg.chan_c, 1'b0});
					lead_stops++;
				end
			end else begin
				zprev = 32'(held_pos) * 32'd100;
				add_stop(zprev, {held_a, 1'b0}, {held_b, 1'b0}, {held_c, 1'b0});
				if (held_mid != MID_W'(NO_EXTRA_MID)) begin
					diff = 32'(seg.position) - 32'(held_pos);
					zmid = zprev + diff * 32'(held_mid);
					add_stop(zmid, 17'(held_a) + 17'(seg.chan_a),
						17'(held_b) + 17'(seg.chan_b), 17'(held_c) + 17'(seg.chan_c));
					mid_stops++;
				end
			end
			held_pos = seg.position;
			held_mid = seg.midpoint;
			held_a = seg.chan_a;
			held_b = seg.chan_b;
			held_c = seg.chan_c;
			have_held = 1;
			if (seg.last) begin
				zcur = 32'(seg.position) * 32'd100;
				add_stop(zcur, {seg.chan_a, 1'b0}, {seg.chan_b, 1'b0}, {seg.chan_c, 1'b0});
				if (zcur < END_POSITION)
					add_stop(32'(END_POSITION), {seg.chan_a, 1'b0}, {seg.chan_b, 1'b0},
						{seg.chan_c, 1'b0});
				if (produced > 0)
					batch[produced-1].list_end = 1'b1;
				have_held = 0;
				trimmed = 0;
			end
			if (produced > 0)
				batch[produced-1].run_last = 1'b1;
			for (int i = 0; i < produced; i++)
				expected_stops.push_back(batch[i]);
		endfunction

		function void compare(string field, longint unsigned want, longint unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				mismatches++;
			end
		endfunction

		function void check_stop(stop_t got);
			stop_t want;
			if (expected_stops.size() == 0) begin
				$error("stop at position %0d with nothing expected", got.position);
				mismatches++;
				return;
			end
			want = expected_stops.pop_front();
			stops_checked++;
			compare("stop_position", want.position, got.position);
			compare("out_a", want.a, got.a);
			compare("out_b", want.b, got.b);
			compare("out_c", want.c, got.c);
			compare("run_last", want.run_last, got.run_last);
			compare("list_end", want.list_end, got.list_end);
			compare("too_few", want.too_few, got.too_few);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [87:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic [1:0]  m_axis_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	stop_tracker_t sb = new();
	// idle percentages of the two sides, changed per phase
	int send_idle_pct = 11;
	int recv_idle_pct = 75;
	// long receiver hold-offs asked by the stimulus and granted by the receiver
	int hold_requests = 0;
	int holds_granted = 0;
	int stall_left = 0;
	int cycles = 0;
	int drains = 0;

	gradient_stop_rectifier_unit #(
		.END_POSITION(END_POSITION)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	// watchdog on the whole run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// stop side: check each accepted transaction, then decide the next tready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_stop('{position: m_axis_tdata[31:0], a: m_axis_tdata[48:32],
					b: m_axis_tdata[65:49], c: m_axis_tdata[82:66],
					run_last: m_axis_tlast, list_end: m_axis_tuser[0],
					too_few: m_axis_tuser[1]});
			// a new hold-off request starts a long stall counted here
			if (holds_granted != hold_requests) begin
				holds_granted <= holds_granted + 1;
				stall_left <= LONG_HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// offer one segment, with a random gap first, and wait for its transaction
	task automatic send_segment(input segment_t seg);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, seg.chan_c, seg.chan_b, seg.chan_a, seg.midpoint, seg.position};
		s_axis_tlast <= seg.last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.take_segment(seg);
	endtask

	// sender pauses until all stops are out and the back end has gone quiet
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		drains++;
	endtask

	// register write in setup and access cycles, only while the block is idle
	task automatic write_channel_mode(input chan_mode_t m);
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_CHANNEL_MODE;
		pwdata <= 32'(m);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.mode = m;
	endtask

	function automatic segment_t make_segment(input logic [POS_W-1:0] pos,
			input logic [MID_W-1:0] mid, input logic [CHAN_W-1:0] a, b, c, input bit last);
		return '{position: pos, midpoint: mid, chan_a: a, chan_b: b, chan_c: c, last: last};
	endfunction

	function automatic logic [CHAN_W-1:0] random_chan();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return CHAN_W'($urandom_range(255));
			default: return CHAN_W'($urandom);
		endcase
	endfunction

	// mostly in-range midpoints, a fair share of 50, a few out of range
	function automatic logic [MID_W-1:0] random_mid();
		case ($urandom_range(7))
			0, 1: return MID_W'(NO_EXTRA_MID);
			2: return MID_W'($urandom_range(127, 101));
			default: return MID_W'($urandom_range(100));
		endcase
	endfunction

	// one gradient: mostly rising positions, now and then a jump anywhere
	task automatic send_gradient(input int nseg, inout int sent);
		logic [POS_W-1:0] pos;
		pos = ($urandom_range(3) == 0) ? '0 : POS_W'($urandom_range(600));
		for (int i = 0; i < nseg; i++) begin
			send_segment(make_segment(pos, random_mid(), random_chan(), random_chan(),
				random_chan(), i == nseg - 1));
			sent++;
			if ($urandom_range(9) == 0)
				pos = POS_W'($urandom);
			else
				pos = pos + POS_W'($urandom_range(1500));
		end
	endtask

	task automatic random_phase(input int count);
		int sent;
		sent = 0;
		while (sent < count)
			send_gradient(($urandom_range(9) == 0) ? 1 : $urandom_range(6, 2), sent);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, color mode
		write_channel_mode(MODE_COLOR);
		// gradient of one segment
		send_segment(make_segment(16'd100, 7'd50, 16'd1, 16'd2, 16'd3, 1));
		// midpoints at 0, 100 and 50, final stop appended below the end
		send_segment(make_segment(16'd0, 7'd0, '0, '0, '0, 0));
		send_segment(make_segment(16'd1000, 7'd100, '1, '1, '1, 0));
		send_segment(make_segment(16'd2000, 7'd50, 16'h5555, 16'haaaa, 16'h00ff, 1));
		// midpoint stop past the end trims the list, later segments yield nothing
		send_segment(make_segment(16'd0, 7'd127, 16'h1234, 16'h8000, 16'h7fff, 0));
		send_segment(make_segment(16'hffff, 7'd50, '1, '1, '1, 0));
		send_segment(make_segment(16'd100, 7'd30, 16'd9, 16'd8, 16'd7, 0));
		send_segment(make_segment(16'd5, 7'd50, 16'd1, 16'd1, 16'd1, 1));
		// falling positions wrap in the midpoint stop
		send_segment(make_segment(16'd3000, 7'd80, 16'hffff, 16'd0, 16'hffff, 0));
		send_segment(make_segment(16'd1000, 7'd20, 16'd0, 16'hffff, 16'd0, 1));

		// opacity mode: leading stop, last stop exactly at the end position
		write_channel_mode(MODE_OPACITY);
		send_segment(make_segment(16'd500, 7'd40, 16'd255, 16'd77, 16'd66, 0));
		send_segment(make_segment(16'd4096, 7'd50, 16'd0, 16'd1, 16'd1, 1));
		// first segment at zero gets no leading stop; mode flips mid-gradient
		send_segment(make_segment(16'd0, 7'd50, 16'hffff, 16'd1, 16'd2, 0));
		send_segment(make_segment(16'd200, 7'd10, 16'd128, 16'd3, 16'd4, 0));
		write_channel_mode(MODE_COLOR);
		send_segment(make_segment(16'd300, 7'd90, 16'd10, 16'd20, 16'd30, 0));
		send_segment(make_segment(16'd400, 7'd50, 16'd40, 16'd50, 16'd60, 1));

		// long receiver hold-off while segments keep coming, the input must stall
		drain();
		send_idle_pct = 0;
		hold_requests++;
		for (int i = 0; i < 6; i++)
			send_segment(make_segment(POS_W'(100 * i), 7'd30, random_chan(), random_chan(),
				random_chan(), i == 5));

		// random part: sender idles little and receiver much, then the reverse, then none
		send_idle_pct = 11;
		recv_idle_pct = 75;
		random_phase(ITEMS_PER_PHASE);
		write_channel_mode(MODE_OPACITY);
		send_idle_pct = 75;
		recv_idle_pct = 11;
		random_phase(ITEMS_PER_PHASE);
		write_channel_mode(MODE_COLOR);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(ITEMS_PER_PHASE);
		drain();

		$display("%0d segments in %0d gradients gave %0d stops (%0d midpoint, %0d leading)",
			sb.segments, sb.gradients, sb.stops_checked, sb.mid_stops, sb.lead_stops);
		$display("%0d trimmed lists, %0d one-segment gradients, %0d idle pauses",
			sb.trimmed_lists, sb.short_gradients, drains);
		if (sb.mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
